### hdl/tdl_pkg.sv
// types, register indexes and constants shared by the thermostat blocks
package tdl_pkg;

	localparam int TIME_BITS       = 32;
	localparam int TEMP_BITS       = 12;
	localparam int BAND_BITS       = 8;
	localparam int LOCKOUT_BITS    = 24;
	localparam int DANGER_BITS     = 16;
	localparam int DANGER_THR_BITS = 26;
	localparam int CFG_IDX_BITS    = 3;
	localparam int CFG_DATA_BITS   = 24;
	localparam int MODE_BITS       = 3;
	localparam int MS_PER_S        = 1000;
	localparam int LEFT_FLOOR_MS   = 1000;

	localparam logic [CFG_IDX_BITS-1:0] REG_SETPOINT    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEADBAND    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_HARM_MARGIN = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOCKOUT_MS  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_DANGER_S    = 3'd4;

	localparam logic [MODE_BITS-1:0] MODE_REST       = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_HEAT       = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_CHILL      = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_HEAT_WARN  = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_CHILL_WARN = 3'd4;

	localparam logic signed [TEMP_BITS-1:0] SETPOINT_RST    = 12'sd400;
	localparam logic [BAND_BITS-1:0]        DEADBAND_RST    = 8'd8;
	localparam logic [BAND_BITS-1:0]        HARM_MARGIN_RST = 8'd24;
	localparam logic [LOCKOUT_BITS-1:0]     LOCKOUT_MS_RST  = 24'd60000;
	localparam logic [DANGER_BITS-1:0]      DANGER_S_RST    = 16'd7200;

	typedef struct packed {
		logic signed [TEMP_BITS-1:0] sample;
		logic [TIME_BITS-1:0]        now_ms;
	} item_t;

	typedef struct packed {
		logic [MODE_BITS-1:0] mode;
		logic                 heater_on;
		logic                 chiller_on;
		logic                 harmful;
		logic [TIME_BITS-1:0] lockout_left_ms;
		logic [TIME_BITS-1:0] last_change_ms;
	} result_t;

	// danger_thr holds (danger_seconds + 1) * 1000: elapsed / 1000 > s <=> elapsed >= thr
	typedef struct packed {
		logic signed [TEMP_BITS-1:0] setpoint;
		logic [BAND_BITS-1:0]        deadband;
		logic [BAND_BITS-1:0]        harm_margin;
		logic [LOCKOUT_BITS-1:0]     lockout_ms;
		logic [DANGER_THR_BITS-1:0]  danger_thr;
	} cfg_t;

	function automatic logic [DANGER_THR_BITS-1:0] danger_thr(
		input logic [DANGER_BITS-1:0] secs
	);
		logic [DANGER_THR_BITS-1:0] s1;
		s1 = DANGER_THR_BITS'(secs) + DANGER_THR_BITS'(1);
		return s1 * DANGER_THR_BITS'(MS_PER_S);
	endfunction

endpackage

### hdl/tdl_cfg.sv
// configuration register file
module tdl_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [tdl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [tdl_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output tdl_pkg::cfg_t                        cfg
);
	import tdl_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint    <= SETPOINT_RST;
			cfg_q.deadband    <= DEADBAND_RST;
			cfg_q.harm_margin <= HARM_MARGIN_RST;
			cfg_q.lockout_ms  <= LOCKOUT_MS_RST;
			cfg_q.danger_thr  <= danger_thr(DANGER_S_RST);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SETPOINT: begin
					cfg_q.setpoint <= cfg_data[TEMP_BITS-1:0];
				end
				REG_DEADBAND: begin
					cfg_q.deadband <= cfg_data[BAND_BITS-1:0];
				end
				REG_HARM_MARGIN: begin
					cfg_q.harm_margin <= cfg_data[BAND_BITS-1:0];
				end
				REG_LOCKOUT_MS: begin
					cfg_q.lockout_ms <= cfg_data[LOCKOUT_BITS-1:0];
				end
				REG_DANGER_S: begin
					cfg_q.danger_thr <= danger_thr(cfg_data[DANGER_BITS-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/tdl_core.sv
// mode decision, lockout and dwell state, result computation
module tdl_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  tdl_pkg::item_t    item_s1,
	input  tdl_pkg::cfg_t     cfg,
	output tdl_pkg::result_t  result_d
);
	import tdl_pkg::*;

	localparam int TW = TEMP_BITS + 2;

	logic [MODE_BITS-1:0] mode_q;
	logic [TIME_BITS-1:0] lockout_end_q;
	logic [TIME_BITS-1:0] last_change_q;

	logic signed [TW-1:0] t, sp, db, hm;
	logic signed [TW-1:0] band_hi, band_lo, harm_hi, harm_lo;
	logic [TIME_BITS-1:0] now, elapsed, end_new, floor_t;
	logic                 go_chill, go_heat, blocked, already, change, over;
	logic [MODE_BITS-1:0] target, mode_n;
	logic [TIME_BITS-1:0] end_n, last_n;

	always_comb begin
		t  = {{2{item_s1.sample[TEMP_BITS-1]}}, item_s1.sample};
		sp = {{2{cfg.setpoint[TEMP_BITS-1]}}, cfg.setpoint};
		db = TW'(cfg.deadband);
		hm = TW'(cfg.harm_margin);
		band_hi = sp + db;
		band_lo = sp - db;
		harm_hi = sp + hm;
		harm_lo = sp - hm;
		now = item_s1.now_ms;

		go_chill = (t >= band_hi);
		go_heat  = !go_chill && (t < band_lo);
		if (go_chill) begin
			target  = MODE_CHILL;
			already = (mode_q == MODE_CHILL) || (mode_q == MODE_CHILL_WARN);
		end else if (go_heat) begin
			target  = MODE_HEAT;
			already = (mode_q == MODE_HEAT) || (mode_q == MODE_HEAT_WARN);
		end else begin
			target  = MODE_REST;
			already = (mode_q == MODE_REST);
		end

		blocked = (lockout_end_q > now);
		change  = !blocked && !already;

		// a fresh change has zero elapsed time, so only a held mode can escalate
		elapsed = now - last_change_q;
		over    = (elapsed >= TIME_BITS'(cfg.danger_thr));
		mode_n  = change ? target : mode_q;
		if (!change && over && (mode_q == MODE_HEAT)) begin
			mode_n = MODE_HEAT_WARN;
		end else if (!change && over && (mode_q == MODE_CHILL)) begin
			mode_n = MODE_CHILL_WARN;
		end

		end_new = now + TIME_BITS'(cfg.lockout_ms);
		end_n   = change ? end_new : lockout_end_q;
		last_n  = change ? now : last_change_q;
		floor_t = now + TIME_BITS'(LEFT_FLOOR_MS);

		result_d.mode            = mode_n;
		result_d.heater_on       = (mode_n == MODE_HEAT) || (mode_n == MODE_HEAT_WARN);
		result_d.chiller_on      = (mode_n == MODE_CHILL) || (mode_n == MODE_CHILL_WARN);
		result_d.harmful         = (t >= harm_hi) || (t <= harm_lo);
		result_d.lockout_left_ms = (end_n > floor_t) ? (end_n - now) : '0;
		result_d.last_change_ms  = last_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_REST;
			lockout_end_q <= '0;
			last_change_q <= '0;
		end else if (advance) begin
			mode_q        <= mode_n;
			lockout_end_q <= end_n;
			last_change_q <= last_n;
		end
	end

endmodule

### hdl/thermostat_deadband_lockout.sv
// Heat / chill / rest thermostat with deadband, mode-change lockout and dwell
// warning. One temperature item is taken per clock while item_stall is low. Each
// result passes through the input register, then the result register, and is
// offered once loaded there; the rate of one item per cycle is set by the
// update of the mode, lockout-end and last-change registers on the edge that loads the result. A finished
// result waiting under stall leaves room for one more item in the input
// register. cfg_ready is always high; registers are to be written only while
// no item is in flight.
module thermostat_deadband_lockout (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  tdl_pkg::item_t                     item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output tdl_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tdl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [tdl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import tdl_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_d;
	result_t result_q;
	logic    result_valid_q;
	logic    out_load, advance, take_in;

	assign cfg_ready  = 1'b1;
	assign out_load   = !result_valid_q || !result_stall;
	assign advance    = valid_s1 && out_load;
	assign item_stall = valid_s1 && !out_load;
	assign take_in    = item_valid && !item_stall;

	tdl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tdl_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item_s1  (item_s1),
		.cfg      (cfg),
		.result_d (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_s1 <= take_in || (valid_s1 && !advance);
			if (out_load) begin
				result_valid_q <= advance;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### hdl/tdl_chk.sv
// port-level checks for the thermostat, bound to the top level
module tdl_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               item_stall,
	input logic                               result_valid,
	input logic                               result_stall,
	input tdl_pkg::result_t                   result
);
	import tdl_pkg::*;

	// a stalled result stays up with the same payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result dropped or changed");

	// relays never both driven
	a_relays: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.heater_on && result.chiller_on))
		else $error("heater and chiller both on");

	a_heater_mode: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.heater_on ==
			((result.mode == MODE_HEAT) || (result.mode == MODE_HEAT_WARN)))
		else $error("heater drive disagrees with mode");

	// input is only held off behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without a stalled result");

	// a heater warn result never carries a fresh change time
	a_warn_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall ##1 result_valid &&
			(result.mode == MODE_HEAT_WARN) && $changed(result.last_change_ms)
		|-> 1'b0)
		else $error("warn mode on a fresh mode change");

endmodule

bind thermostat_deadband_lockout tdl_chk u_chk (.*);

### bench/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the deadband thermostat with mode-change lockout
module tb;
	import tdl_pkg::*;

	// index past the last register, writes to it must change nothing
	localparam logic [CFG_IDX_BITS-1:0] REG_NONE = '1;
	localparam int RAND_ITEMS = 160;
	localparam int N_PHASES   = 8;
	localparam int LONG_HOLD  = 80;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     item_valid = 1'b0;
	logic                     item_stall;
	item_t                    item = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	result_t                  result;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// registers and state as the thermostat should hold them
	logic signed [TEMP_BITS-1:0] sp_reg      = SETPOINT_RST;
	logic [BAND_BITS-1:0]        band_reg    = DEADBAND_RST;
	logic [BAND_BITS-1:0]        margin_reg  = HARM_MARGIN_RST;
	logic [LOCKOUT_BITS-1:0]     lockout_reg = LOCKOUT_MS_RST;
	logic [DANGER_BITS-1:0]      danger_reg  = DANGER_S_RST;
	logic [MODE_BITS-1:0]        mode_st     = MODE_REST;
	logic [TIME_BITS-1:0]        lock_end_st = '0;
	logic [TIME_BITS-1:0]        changed_at  = '0;

	item_t   sample_q[$];
	result_t status_q[$];
	int      n_bad = 0;

	logic in_took = 1'b0;
	int   in_gap = 0;
	int   in_fast = 0;
	logic out_took = 1'b0;
	int   out_wait = 0;
	int   out_fast = 0;
	logic hold_req = 1'b0;

	thermostat_deadband_lockout DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic result_t thermo_next(input item_t it);
		int t, sp, db, hm;
		logic [TIME_BITS-1:0] now, secs, thr;
		logic blocked;
		logic [MODE_BITS-1:0] want;
		result_t r;
		t = $signed(it.sample);
		sp = $signed(sp_reg);
		db = int'(band_reg);
		hm = int'(margin_reg);
		now = it.now_ms;
		blocked = lock_end_st > now;
		if (t >= sp + db) want = MODE_CHILL;
		else if (t < sp - db) want = MODE_HEAT;
		else want = MODE_REST;
		// a warn mode already counts as running in its direction
		if (!blocked && want != mode_st
				&& !(want == MODE_HEAT && mode_st == MODE_HEAT_WARN)
				&& !(want == MODE_CHILL && mode_st == MODE_CHILL_WARN)) begin
			mode_st = want;
			changed_at = now;
			lock_end_st = now + TIME_BITS'(lockout_reg);
		end
		secs = (now - changed_at) / TIME_BITS'(MS_PER_S);
		if (secs > TIME_BITS'(danger_reg)) begin
			if (mode_st == MODE_HEAT) mode_st = MODE_HEAT_WARN;
			else if (mode_st == MODE_CHILL) mode_st = MODE_CHILL_WARN;
		end
		// plain compare, so a wrapped threshold still reports time left
		thr = now + TIME_BITS'(LEFT_FLOOR_MS);
		r.mode = mode_st;
		r.heater_on = (mode_st == MODE_HEAT || mode_st == MODE_HEAT_WARN);
		r.chiller_on = (mode_st == MODE_CHILL || mode_st == MODE_CHILL_WARN);
		r.harmful = (t >= sp + hm) || (t <= sp - hm);
		r.lockout_left_ms = (lock_end_st > thr) ? lock_end_st - now : '0;
		r.last_change_ms = changed_at;
		return r;
	endfunction

	function automatic void cmp_field(input string name, input logic [TIME_BITS-1:0] want,
			input logic [TIME_BITS-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			n_bad++;
		end
	endfunction

	task automatic queue_sample(input int s, input logic [TIME_BITS-1:0] now);
		item_t it;
		it.sample = TEMP_BITS'(s);
		it.now_ms = now;
		sample_q.push_back(it);
	endtask

	task automatic reg_write(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_SETPOINT: sp_reg = data[TEMP_BITS-1:0];
			REG_DEADBAND: band_reg = data[BAND_BITS-1:0];
			REG_HARM_MARGIN: margin_reg = data[BAND_BITS-1:0];
			REG_LOCKOUT_MS: lockout_reg = data[LOCKOUT_BITS-1:0];
			REG_DANGER_S: danger_reg = data[DANGER_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (sample_q.size() != 0 || item_valid || status_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// input side: predict at the transfer, offer the next item at the falling edge
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			status_q.push_back(thermo_next(item));
			in_took = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!item_valid || in_took)) begin
			in_took = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
				item_valid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				item <= sample_q.pop_front();
				item_valid <= 1'b1;
				if (in_fast > 0) begin
					in_fast--;
					in_gap = 0;
				end else begin
					in_gap = $urandom_range(0, 9);
					if ($urandom_range(0, 39) == 0) in_fast = $urandom_range(20, 60);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// output side: check each transfer against the oldest expected status
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			out_took = 1'b1;
			if (status_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				n_bad++;
			end else begin
				result_t e;
				e = status_q.pop_front();
				cmp_field("mode", e.mode, result.mode);
				cmp_field("heater_on", e.heater_on, result.heater_on);
				cmp_field("chiller_on", e.chiller_on, result.chiller_on);
				cmp_field("harmful", e.harmful, result.harmful);
				cmp_field("lockout_left_ms", e.lockout_left_ms, result.lockout_left_ms);
				cmp_field("last_change_ms", e.last_change_ms, result.last_change_ms);
			end
		end
	end

	always @(negedge clk) begin
		if (out_took) begin
			out_took = 1'b0;
			if (out_fast > 0) begin
				out_fast--;
				out_wait = 0;
			end else begin
				out_wait = $urandom_range(0, 9);
				if ($urandom_range(0, 39) == 0) out_fast = $urandom_range(20, 60);
			end
		end
		if (hold_req) begin
			hold_req = 1'b0;
			out_wait = LONG_HOLD;
		end
		if (out_wait > 0) begin
			out_wait--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	initial begin
		int s, k, span, sp, db, hm;
		int sp_v, db_v, hm_v, lk_v, dg_v;
		int bound[8];
		logic [TIME_BITS-1:0] clock_ms, junk;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: band edges, lockout expiry, warn entry, time wrap
		queue_sample(400, 0);
		queue_sample(408, 10);
		queue_sample(391, 20);
		queue_sample(392, 59009);
		queue_sample(392, 59010);
		queue_sample(392, 60010);
		queue_sample(-2048, 120010);
		queue_sample(2047, 120011);
		queue_sample(424, 130000);
		queue_sample(376, 130001);
		queue_sample(377, 130002);
		queue_sample(0, 120010 + 7200999);
		queue_sample(0, 120010 + 7201000);
		queue_sample(0, 120010 + 7300000);
		queue_sample(2000, 7500000);
		queue_sample(2000, 7500000 + 7201000);
		queue_sample(400, 7500000 + 7300000);
		queue_sample(2000, 32'hFFFF_1500);
		queue_sample(0, 32'hFFFF_FF00);
		queue_sample(0, 32'hFFFF_FF70);
		queue_sample(400, 32'hFFFF_FF80);
		queue_sample(400, 5);
		queue_sample(-1, 100);
		wait_idle();

		clock_ms = 200000;
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin
					sp_v = -2048; db_v = 0; hm_v = 0; lk_v = 0; dg_v = 0;
				end
				1: begin
					sp_v = 2047; db_v = 255; hm_v = 255; lk_v = 24'hFF_FFFF; dg_v = 16'hFFFF;
				end
				default: begin
					sp_v = int'($urandom_range(0, 2880)) - 880;
					db_v = $urandom_range(0, 40);
					hm_v = $urandom_range(0, 80);
					lk_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000)
						: $urandom_range(1000, 120000);
					dg_v = $urandom_range(0, 20);
				end
			endcase
			junk = $urandom();
			reg_write(REG_SETPOINT, {junk[11:0], TEMP_BITS'(sp_v)});
			reg_write(REG_DEADBAND, {junk[15:0], BAND_BITS'(db_v)});
			reg_write(REG_HARM_MARGIN, {junk[31:16], BAND_BITS'(hm_v)});
			reg_write(REG_LOCKOUT_MS, LOCKOUT_BITS'(lk_v));
			reg_write(REG_DANGER_S, {junk[7:0], DANGER_BITS'(dg_v)});
			if (p == 2) reg_write(REG_NONE, junk[23:0]);
			if (p == 3) clock_ms = 32'hFFF0_0000;

			sp = $signed(sp_reg);
			db = int'(band_reg);
			hm = int'(margin_reg);
			span = db + hm + 4;
			bound = '{sp + db, sp + db - 1, sp - db, sp - db - 1,
				sp + hm, sp + hm - 1, sp - hm, sp - hm + 1};
			for (int i = 0; i < RAND_ITEMS; i++) begin
				k = $urandom_range(0, 19);
				if (k < 10) clock_ms += $urandom_range(0, 1500);
				else if (k < 15) clock_ms += $urandom_range(0, lockout_reg + 2000);
				else if (k < 18) clock_ms += $urandom_range(0, danger_reg * 1000 + 5000);
				else if (k == 18) clock_ms -= $urandom_range(0, 5000);
				else clock_ms = $urandom();
				k = $urandom_range(0, 9);
				if (k < 6) s = sp + int'($urandom_range(0, 2 * span)) - span;
				else if (k < 8) s = bound[$urandom_range(0, 7)];
				else s = $urandom_range(0, 4095);
				queue_sample(s, clock_ms);
			end
			// long receiver hold-off while the sender keeps pushing
			if (p == 4) begin
				repeat (20) @(posedge clk);
				in_fast = 100;
				hold_req = 1'b1;
			end
			wait_idle();
		end

		if (n_bad == 0) begin
			$display("thermostat_deadband_lockout: match");
		end else begin
			$display("thermostat_deadband_lockout: mismatch");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("thermostat_deadband_lockout: mismatch");
		$finish;
	end

endmodule
